FILE: sv/swrf_pkg.sv
// Shared types, constants and the exponential weight table for the
// sliding-window weighted rank filter. Depends on nothing.
package swrf_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int SAMPLE_W     = 24;
    localparam int REG_W        = 16;
    localparam int ROM_SIZE     = 1024;
    localparam int ROM_AW       = 10;
    localparam int WEIGHT_W     = 16;
    localparam int WSUM_W       = PTR_W + WEIGHT_W;
    localparam int ACC_W        = SAMPLE_W + WEIGHT_W + PTR_W + 2;
    localparam int POS_W        = 17;

    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_SHARP  = 2'd1;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_REMOVE = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_LOAD   = 2'd3;

    // exp(-1/64) in Q62 from its alternating series; term n is term n-1 over 64n.
    localparam logic [63:0] Q62_ONE = 64'd1 << 62;
    localparam logic [63:0] EXP_T1  = Q62_ONE / 64'd64;
    localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd128;
    localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd192;
    localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd256;
    localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd320;
    localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd384;
    localparam logic [63:0] EXP_T7  = EXP_T6 / 64'd448;
    localparam logic [63:0] EXP_T8  = EXP_T7 / 64'd512;
    localparam logic [63:0] EXP_T9  = EXP_T8 / 64'd576;
    localparam logic [63:0] EXP_T10 = EXP_T9 / 64'd640;
    localparam logic [63:0] EXP_T11 = EXP_T10 / 64'd704;
    localparam logic [63:0] EXP_T12 = EXP_T11 / 64'd768;
    localparam logic [63:0] EXP_T13 = EXP_T12 / 64'd832;
    localparam logic [63:0] EXP_T14 = EXP_T13 / 64'd896;
    localparam logic [63:0] EXP_RATIO = Q62_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                        - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                        + EXP_T10 - EXP_T11 + EXP_T12 - EXP_T13
                                        + EXP_T14;

    typedef logic [WEIGHT_W-1:0] rom_t [ROM_SIZE];

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [SAMPLE_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic                       valid;
        logic                       lt;
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] copy;
    } cell_link_t;

    typedef struct packed {
        logic                start;
        logic [ACC_W-1:0]    dividend;
        logic [WSUM_W-1:0]   divisor;
    } div_req_t;

    // round(65535 * exp(-k/64)), stepping by the Q62 ratio exp(-1/64).
    function automatic rom_t build_exp_rom();
        rom_t         rom;
        logic [63:0]  v;
        logic [63:0]  v46;
        logic [127:0] prod;
        v = Q62_ONE;
        for (int k = 0; k < ROM_SIZE; k++) begin
            v46    = v >> 16;
            rom[k] = WEIGHT_W'((v46 * 64'd65535 + (64'd1 << 45)) >> 46);
            prod   = {64'd0, v} * {64'd0, EXP_RATIO};
            v      = prod[125:62];
        end
        return rom;
    endfunction

    localparam rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: sv/swrf_cell.sv
// One cell of the sorted chain: holds one ranked sample and a readout copy.
// Depends on swrf_pkg.
module swrf_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swrf_pkg::cell_ctrl_t   ctrl,
    input  swrf_pkg::cell_link_t   prev_link,
    input  swrf_pkg::cell_link_t   next_link,
    output swrf_pkg::cell_link_t   link
);
    import swrf_pkg::*;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] copy_reg;
    logic                       lt;

    // An empty cell behaves as if it held plus infinity.
    assign lt   = !valid_reg || (ctrl.value < value_reg);
    assign link = '{valid: valid_reg, lt: lt, value: value_reg, copy: copy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            case (ctrl.op)
                CELL_REMOVE: begin
                    if (valid_reg && !(value_reg < ctrl.value)) begin
                        valid_reg <= next_link.valid;
                    end
                end
                CELL_INSERT: begin
                    if (lt) begin
                        valid_reg <= prev_link.lt ? prev_link.valid : 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            CELL_REMOVE: begin
                if (valid_reg && !(value_reg < ctrl.value)) value_reg <= next_link.value;
            end
            CELL_INSERT: begin
                if (lt) value_reg <= prev_link.lt ? prev_link.value : ctrl.value;
            end
            default: ;
        endcase
        if (ctrl.op == CELL_LOAD) copy_reg <= value_reg;
        else copy_reg <= next_link.copy;
    end

endmodule

FILE: sv/swrf_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on swrf_pkg.
module swrf_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  swrf_pkg::div_req_t         req,
    output logic                       done,
    output logic [swrf_pkg::ACC_W-1:0] quotient,
    output logic [swrf_pkg::WSUM_W-1:0] remainder
);
    import swrf_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [ACC_W-1:0]    quo_reg;
    logic [WSUM_W-1:0]   rem_reg;
    logic [WSUM_W-1:0]   div_reg;
    logic [WSUM_W:0]     shifted;
    logic [WSUM_W:0]     trial;

    assign shifted   = {rem_reg, quo_reg[ACC_W-1]};
    assign trial     = shifted - {1'b0, div_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ACC_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end else if (busy_reg) begin
            if (!trial[WSUM_W]) begin
                rem_reg <= trial[WSUM_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[WSUM_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: sv/sliding_window_weighted_rank_filter_top.sv
// Top level of the sliding-window weighted rank filter: control, arrival
// memory, weight pipeline. Depends on swrf_pkg, swrf_cell and swrf_divider.
//
// Each request carries one signed 24-bit sample; the block keeps the newest
// 64 in a memory and, ranked, in a chain of cells, and returns one result
// per request: the mean of the ranked samples weighted by a peak decaying
// exponentially around the center position, truncated toward zero. A
// request removes the oldest sample from the chain once the window is full,
// inserts the new one and runs a 48-step division for the rank spacing,
// one rank per cycle as the cell chain shifts its copies out, a
// five-stage weight pipeline and a second 48-step division. A new request
// is taken while the previous result still waits on the output.
module sliding_window_weighted_rank_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] filtered
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import swrf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_REM   = 4'd1;
    localparam logic [3:0] ST_INS   = 4'd2;
    localparam logic [3:0] ST_LOAD  = 4'd3;
    localparam logic [3:0] ST_DIVQ  = 4'd4;
    localparam logic [3:0] ST_WALK  = 4'd5;
    localparam logic [3:0] ST_DRAIN = 4'd6;
    localparam logic [3:0] ST_DIVF  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]                 state_reg;
    logic [REG_W-1:0]           center_reg;
    logic [REG_W-1:0]           sharp_reg;
    logic signed [SAMPLE_W-1:0] arrival_mem [WINDOW_DEPTH];
    logic signed [SAMPLE_W-1:0] old_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [CNT_W-1:0]           n_m1_reg;
    logic [CNT_W-1:0]           walk_reg;
    logic [POS_W-1:0]           step_q_reg;
    logic [CNT_W-1:0]           step_r_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [CNT_W:0]             rem_sum;
    logic                       rem_wrap;
    logic signed [POS_W:0]      diff;

    logic [3:0]                 pv_reg;
    logic signed [SAMPLE_W-1:0] samp0_reg, samp1_reg, samp2_reg;
    logic [REG_W-1:0]           d_reg;
    logic [31:0]                dprod;
    logic [ROM_AW-1:0]          idx_reg;
    logic [WEIGHT_W-1:0]        w_reg, w3_reg;
    logic signed [SAMPLE_W+WEIGHT_W:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [WSUM_W-1:0]          wsum_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_tdata_reg;

    logic                       s_accept;
    logic                       full;
    cell_ctrl_t                 cell_ctrl;
    cell_link_t                 links [WINDOW_DEPTH];
    div_req_t                   div_req;
    logic                       div_done;
    logic [ACC_W-1:0]           div_quo;
    logic [WSUM_W-1:0]          div_rem;
    logic [ACC_W-1:0]           div_signed_q;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (fill_reg == CNT_W'(WINDOW_DEPTH));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        cell_ctrl = '{op: CELL_HOLD, value: sample_reg};
        case (state_reg)
            ST_REM:  cell_ctrl = '{op: CELL_REMOVE, value: old_reg};
            ST_INS:  cell_ctrl = '{op: CELL_INSERT, value: sample_reg};
            ST_LOAD: cell_ctrl = '{op: CELL_LOAD, value: sample_reg};
            ST_DIVQ: cell_ctrl = '{op: CELL_LOAD, value: sample_reg};
            default: ;
        endcase
    end

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        cell_link_t prev_l;
        cell_link_t next_l;
        if (g == 0) begin : g_first
            assign prev_l = '0;
        end else begin : g_mid
            assign prev_l = links[g-1];
        end
        if (g == WINDOW_DEPTH - 1) begin : g_last
            assign next_l = '0;
        end else begin : g_body
            assign next_l = links[g+1];
        end
        swrf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (links[g])
        );
    end

    always_comb begin
        div_req = '{start: 1'b0, dividend: ACC_W'(16'hFFFF),
                    divisor: WSUM_W'(fill_reg - 1'b1)};
        if (state_reg == ST_LOAD && fill_reg != CNT_W'(1)) begin
            div_req.start = 1'b1;
        end else if (state_reg == ST_DRAIN && pv_reg == 4'd0 && wsum_reg != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            div_req.divisor  = wsum_reg;
        end
    end

    swrf_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign div_signed_q = neg_reg ? (~div_quo + 1'b1) : div_quo;

    // Rank position steps by the quotient, with the remainder carried.
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, step_r_reg};
    assign rem_wrap = (rem_sum >= {1'b0, n_m1_reg});
    assign diff     = $signed({2'b00, pos_reg[POS_W-2:0]} | {1'b0, pos_reg[POS_W-1], 16'd0})
                      - $signed({2'b00, center_reg});
    assign dprod    = sharp_reg * d_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            arrival_mem[full ? ptr_reg : fill_reg[PTR_W-1:0]] <= $signed(s_tdata);
        end
        old_reg <= arrival_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            center_reg   <= 16'd32768;
            sharp_reg    <= 16'd8192;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            pv_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_CENTER) center_reg <= cfg_wdata;
            if (cfg_we && cfg_index == REG_SHARP) sharp_reg <= cfg_wdata;
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) m_tvalid_reg <= 1'b0;
            pv_reg <= {pv_reg[2:0], state_reg == ST_WALK};
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (full) begin
                            ptr_reg   <= ptr_reg + 1'b1;
                            state_reg <= ST_REM;
                        end else begin
                            state_reg <= ST_INS;
                        end
                    end
                end
                ST_REM: state_reg <= ST_INS;
                ST_INS: begin
                    if (!full) fill_reg <= fill_reg + 1'b1;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    state_reg <= (fill_reg == CNT_W'(1)) ? ST_OUT : ST_DIVQ;
                end
                ST_DIVQ: begin
                    if (div_done) state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (walk_reg == n_m1_reg) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (pv_reg == 4'd0) begin
                        state_reg <= (wsum_reg == '0) ? ST_OUT : ST_DIVF;
                    end
                end
                ST_DIVF: begin
                    if (div_done) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) sample_reg <= $signed(s_tdata);
        if (state_reg == ST_LOAD) begin
            n_m1_reg   <= fill_reg - 1'b1;
            result_reg <= links[0].value;
        end
        if (state_reg == ST_DIVQ && div_done) begin
            step_q_reg <= div_quo[POS_W-1:0];
            step_r_reg <= div_rem[CNT_W-1:0];
            pos_reg    <= '0;
            rem_reg    <= '0;
            walk_reg   <= '0;
            acc_reg    <= '0;
            wsum_reg   <= '0;
        end
        if (state_reg == ST_WALK) begin
            samp0_reg <= links[0].copy;
            d_reg     <= diff[POS_W] ? REG_W'(-diff) : REG_W'(diff);
            walk_reg  <= walk_reg + 1'b1;
            if (rem_wrap) begin
                rem_reg <= CNT_W'(rem_sum - {1'b0, n_m1_reg});
                pos_reg <= pos_reg + step_q_reg + 1'b1;
            end else begin
                rem_reg <= rem_sum[CNT_W-1:0];
                pos_reg <= pos_reg + step_q_reg;
            end
        end
        idx_reg   <= dprod[31:22];
        samp1_reg <= samp0_reg;
        w_reg     <= EXP_ROM[idx_reg];
        samp2_reg <= samp1_reg;
        prod_reg  <= samp2_reg * $signed({1'b0, w_reg});
        w3_reg    <= w_reg;
        if (pv_reg[3]) begin
            acc_reg  <= acc_reg + ACC_W'(prod_reg);
            wsum_reg <= wsum_reg + WSUM_W'(w3_reg);
        end
        if (state_reg == ST_DRAIN && pv_reg == 4'd0) begin
            neg_reg <= acc_reg[ACC_W-1];
            if (wsum_reg == '0) result_reg <= '0;
        end
        if (state_reg == ST_DIVF && div_done) result_reg <= div_signed_q[SAMPLE_W-1:0];
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) m_tdata_reg <= result_reg;
    end

endmodule
